[sv/tql_pkg.sv]
package tql_pkg;

  // Request and result payloads
  typedef struct packed {
    logic               req_type;
    logic [7:0]         state_index;
    logic [2:0]         action_index;
    logic signed [31:0] reward;
    logic [7:0]         next_state;
    logic [15:0]        dice;
    logic [2:0]         random_action;
  } req_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic               explored;
    logic signed [31:0] updated_value;
  } rsp_t;

  // Configuration register contents
  typedef struct packed {
    logic [15:0] learn_rate;
    logic [15:0] discount;
    logic [15:0] explore_threshold;
    logic [3:0]  actions_in_use;
  } cfg_t;

  localparam logic REQ_CHOOSE = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_LEARN_RATE        = 2'd0,
    REG_DISCOUNT          = 2'd1,
    REG_EXPLORE_THRESHOLD = 2'd2,
    REG_ACTIONS_IN_USE    = 2'd3
  } reg_idx_t;

  localparam logic [15:0] LEARN_RATE_RST        = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST          = 16'd58982;
  localparam logic [15:0] EXPLORE_THRESHOLD_RST = 16'd6554;
  localparam logic [3:0]  ACTIONS_IN_USE_RST    = 4'd8;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_QWAIT = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_SUM   = 9'b000100000,
    ST_TGT   = 9'b001000000,
    ST_DIFF  = 9'b010000000,
    ST_WRITE = 9'b100000000
  } state_t;

endpackage

[sv/tabular_q_learning_update_top.sv]
// Tabular Q-learning engine with epsilon-greedy choice. The value table sits in one
// synchronous RAM of NUM_STATES*NUM_ACTIONS entries; after reset the block stays busy
// while it zeroes all of them (2048 by default), one entry a cycle. A request is taken
// when start is high and busy is low, and exactly one result follows on result, marked
// by done for a single cycle; the result cannot be held off. An exploring choose raises
// done the cycle after the transfer and never raises busy; a greedy choose keeps busy
// high while it issues one RAM read per effective action of the row and waits for the
// last read; an update keeps busy high through a scan of the next state's row, a read of
// the entry, two passes through the shared 16-bit fractional multiplier, saturating adds
// and the write-back. done rises in the same cycle that busy falls. One request is in
// flight at a time, so the write-back always lands before the next request's reads.
module tabular_q_learning_update_top
  import tql_pkg::*;
#(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output rsp_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int VW    = VALUE_WIDTH;
  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(NUM_STATES);
  localparam int EW    = ((VW > 32) ? VW : 32) + 2;

  localparam logic signed [EW-1:0] VMAX_E = EW'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;
  localparam logic signed [EW-1:0] OMAX_E = EW'({1'b0, {31{1'b1}}});
  localparam logic signed [EW-1:0] OMIN_E = ~OMAX_E;

  function automatic logic signed [VW-1:0] sat_vw(input logic signed [EW-1:0] v);
    if (v > VMAX_E) return VMAX_E[VW-1:0];
    if (v < VMIN_E) return VMIN_E[VW-1:0];
    return v[VW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [EW-1:0] v);
    if (v > OMAX_E) return OMAX_E[31:0];
    if (v < OMIN_E) return OMIN_E[31:0];
    return v[31:0];
  endfunction

  cfg_t cfg;

  tql_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Constant tables: state index wrap and action index modulo the action count
  logic [SW-1:0] st_lut  [256];
  logic [2:0]    act_lut [128];

  for (genvar g = 0; g < 256; g++) begin : g_st_lut
    localparam int ST_WRAP = g % NUM_STATES;
    assign st_lut[g] = SW'(ST_WRAP);
  end

  for (genvar g = 0; g < 128; g++) begin : g_act_lut
    localparam int ACT_CNT = ((g / 8) == 0) ? 1 : (g / 8);
    localparam int ACT_WRAP = (g % 8) % ACT_CNT;
    assign act_lut[g] = 3'(ACT_WRAP);
  end

  // Effective action count
  logic [3:0] n_eff;

  always_comb begin
    if (cfg.actions_in_use == 4'd0) begin
      n_eff = 4'd1;
    end else if (7'(cfg.actions_in_use) > 7'(NUM_ACTIONS)) begin
      n_eff = 4'(NUM_ACTIONS);
    end else begin
      n_eff = cfg.actions_in_use;
    end
  end

  // Request decode
  logic          accept;
  logic          req_upd;
  logic          explore;
  logic [SW-1:0] req_st;
  logic [SW-1:0] req_nx;
  logic [2:0]    req_act;
  logic [2:0]    rnd_act;

  assign accept  = start & ~busy;
  assign req_upd = (req.req_type == REQ_UPDATE);
  assign explore = (req.dice < cfg.explore_threshold);
  assign req_st  = st_lut[req.state_index];
  assign req_nx  = st_lut[req.next_state];
  assign req_act = act_lut[{n_eff, req.action_index}];
  assign rnd_act = act_lut[{n_eff, req.random_action}];

  // Registers
  state_t                state;
  state_t                state_next;
  logic [AW-1:0]         clr_addr;
  logic                  rv;
  logic                  is_update;
  logic [2:0]            act_r;
  logic signed [31:0]    reward_r;
  logic [AW-1:0]         base;
  logic [AW-1:0]         q_addr;
  logic [3:0]            rd_cnt;
  logic [3:0]            rv_act;
  logic signed [VW-1:0]  best_val;
  logic [3:0]            best_act;
  logic signed [VW-1:0]  q;
  logic [15:0]           sc_frac;
  logic signed [VW:0]    sc_val;
  logic [31:0]           pl;
  logic signed [VW+1:0]  ph;
  logic signed [VW:0]    sc_sum;
  logic signed [VW-1:0]  target;
  logic                  phase;

  // RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VW-1:0]         ram_rdata;

  tql_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Running maximum over the scanned row
  logic                 take;
  logic signed [VW-1:0] best_val_next;
  logic [3:0]           best_act_next;
  logic                 scan_issue;
  logic                 scan_last;

  assign take          = rv & ((rv_act == 4'd0) | ($signed(ram_rdata) > best_val));
  assign best_val_next = take ? $signed(ram_rdata) : best_val;
  assign best_act_next = take ? rv_act : best_act;
  assign scan_issue    = (state == ST_SCAN) & (rd_cnt != n_eff);
  assign scan_last     = (state == ST_SCAN) & rv & (rv_act == (n_eff - 4'd1));

  // Shared fractional multiplier: frac * v split into a low and a high partial product
  logic signed [VW-16:0] sc_hi;
  logic [31:0]           pl_comb;
  logic signed [VW+1:0]  ph_comb;
  logic signed [VW+1:0]  sum_comb;
  logic signed [VW-1:0]  nq;
  logic signed [31:0]    out_val;

  assign sc_hi    = sc_val[VW:16];
  assign pl_comb  = sc_frac * sc_val[15:0];
  assign ph_comb  = $signed({1'b0, sc_frac}) * sc_hi;
  assign sum_comb = ph + (VW+2)'($signed({1'b0, pl[31:16]}));
  assign nq       = sat_vw(EW'(q) + EW'(sc_sum));
  assign out_val  = sat_out(EW'(nq));

  // RAM port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = q_addr;
    if (scan_issue) begin
      ram_re    = 1'b1;
      ram_raddr = base + AW'(rd_cnt);
    end else if ((state == ST_SCAN) && is_update) begin
      ram_re    = 1'b1;
      ram_raddr = q_addr;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = q_addr;
    ram_wdata = nq;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_WRITE) begin
      ram_we    = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (req_upd || !explore)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (is_update) begin
          if (rd_cnt == n_eff) state_next = ST_QWAIT;
        end else if (scan_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_QWAIT: state_next = ST_MUL;
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = phase ? ST_WRITE : ST_TGT;
      ST_TGT:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      rv       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      done <= (accept & ~req_upd & explore) | (scan_last & ~is_update) | (state == ST_WRITE);
      rv   <= scan_issue;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Capture the request
    if (accept) begin
      is_update <= req_upd;
      act_r     <= req_act;
      reward_r  <= req.reward;
      base      <= AW'(req_upd ? req_nx : req_st) * AW'(NUM_ACTIONS);
      q_addr    <= AW'(req_st) * AW'(NUM_ACTIONS) + AW'(req_act);
      rd_cnt    <= '0;
      phase     <= 1'b0;
    end
    // Advance the row scan
    if (scan_issue) begin
      rd_cnt <= rd_cnt + 4'd1;
      rv_act <= rd_cnt;
    end
    if (rv) begin
      best_val <= best_val_next;
      best_act <= best_act_next;
    end
    // Arithmetic sequence
    case (state)
      ST_QWAIT: begin
        q       <= $signed(ram_rdata);
        sc_frac <= cfg.discount;
        sc_val  <= (VW+1)'(best_val);
      end
      ST_MUL: begin
        pl <= pl_comb;
        ph <= ph_comb;
      end
      ST_SUM: begin
        sc_sum <= sum_comb[VW:0];
      end
      ST_TGT: begin
        target <= sat_vw(EW'(reward_r) + EW'(sc_sum));
      end
      ST_DIFF: begin
        sc_frac <= cfg.learn_rate;
        sc_val  <= (VW+1)'(target) - (VW+1)'(q);
        phase   <= 1'b1;
      end
      default: ;
    endcase
    // Result payload
    if (accept && !req_upd && explore) begin
      result.chosen_action <= rnd_act;
      result.explored      <= 1'b1;
      result.updated_value <= '0;
    end else if (scan_last && !is_update) begin
      result.chosen_action <= best_act_next[2:0];
      result.explored      <= 1'b0;
      result.updated_value <= '0;
    end else if (state == ST_WRITE) begin
      result.chosen_action <= act_r;
      result.explored      <= 1'b0;
      result.updated_value <= out_val;
    end
  end

endmodule

[sv/tql_ram.sv]
module tql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/tql_cfg.sv]
module tql_cfg
  import tql_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Update a register on a completed write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate        <= LEARN_RATE_RST;
      cfg.discount          <= DISCOUNT_RST;
      cfg.explore_threshold <= EXPLORE_THRESHOLD_RST;
      cfg.actions_in_use    <= ACTIONS_IN_USE_RST;
    end else if (wr) begin
      case (idx)
        REG_LEARN_RATE:        cfg.learn_rate        <= pwdata[15:0];
        REG_DISCOUNT:          cfg.discount          <= pwdata[15:0];
        REG_EXPLORE_THRESHOLD: cfg.explore_threshold <= pwdata[15:0];
        REG_ACTIONS_IN_USE:    cfg.actions_in_use    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_LEARN_RATE:        prdata = {16'd0, cfg.learn_rate};
      REG_DISCOUNT:          prdata = {16'd0, cfg.discount};
      REG_EXPLORE_THRESHOLD: prdata = {16'd0, cfg.explore_threshold};
      REG_ACTIONS_IN_USE:    prdata = {28'd0, cfg.actions_in_use};
      default:               prdata = '0;
    endcase
  end

endmodule

[sv/tql_checker.sv]
module tql_checker
  import tql_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // Reset starts the table clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // Every result traces back to a transfer or to work in progress
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a request");

  // An exploring choice is answered in the cycle after its transfer
  a_explore_fast: assert property (@(posedge clk) disable iff (rst)
    (done && result.explored) |-> $past(start && !busy))
    else $error("late exploring result");

  // Work only starts on a transfer or on reset
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) || $past(rst)))
    else $error("busy rose without a transfer");

endmodule

bind tabular_q_learning_update_top tql_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[tb/tabular_q_learning_update_top_tb.sv]
`timescale 1ns / 1ps

module tabular_q_learning_update_top_tb
  import tql_pkg::*;
();

  localparam int NUM_STATES     = 256;
  localparam int NUM_ACTIONS    = 8;
  localparam int TABLE_DEPTH    = NUM_STATES * NUM_ACTIONS;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int RANDOM_ITEMS   = 750;
  localparam int RANDOM_PHASES  = 6;

  localparam longint VAL_HI = 64'sd2147483647;
  localparam longint VAL_LO = -64'sd2147483648;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  logic              done;
  rsp_t              result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow of the value table and the configuration registers
  logic signed [31:0] q_values [0:TABLE_DEPTH-1];
  logic [15:0]        cfg_learn;
  logic [15:0]        cfg_discount;
  logic [15:0]        cfg_explore;
  logic [3:0]         cfg_actions;

  // Action/value results awaited from the block, oldest first
  rsp_t action_value_queue [$];
  rsp_t want;

  int fails;
  int idle_cycles;
  int burst_left;
  int n_choose;
  int n_update;
  int n_explored;
  int n_settings;

  tabular_q_learning_update_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Q-learning step model
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] sat32(longint v);
    if (v > VAL_HI) return 32'sh7FFFFFFF;
    if (v < VAL_LO) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor(frac * v / 65536)
  function automatic longint frac_mul(logic [15:0] frac, longint v);
    longint p;
    p = longint'({48'd0, frac}) * v;
    return p >>> 16;
  endfunction

  function automatic int live_actions();
    int n;
    n = int'(cfg_actions);
    if (n == 0) n = 1;
    if (n > NUM_ACTIONS) n = NUM_ACTIONS;
    return n;
  endfunction

  // First action of the row with the highest value
  function automatic int best_in_row(logic [7:0] st, int n, output longint best_val);
    int best;
    longint v;
    best = 0;
    best_val = q_values[int'(st) * NUM_ACTIONS];
    for (int a = 1; a < n; a++) begin
      v = q_values[int'(st) * NUM_ACTIONS + a];
      if (v > best_val) begin
        best_val = v;
        best = a;
      end
    end
    return best;
  endfunction

  function automatic rsp_t step_q_engine(req_t r);
    rsp_t   o;
    int     n;
    int     act;
    int     idx;
    longint maxq;
    longint tgt;
    longint q;
    longint nq;
    n = live_actions();
    o = '0;
    if (r.req_type == REQ_CHOOSE) begin
      if (r.dice < cfg_explore) begin
        act = int'(r.random_action) % n;
        o.explored = 1'b1;
      end else begin
        act = best_in_row(r.state_index, n, maxq);
      end
      o.chosen_action = 3'(act);
    end else begin
      act = int'(r.action_index) % n;
      idx = int'(r.state_index) * NUM_ACTIONS + act;
      void'(best_in_row(r.next_state, n, maxq));
      tgt = sat32(longint'($signed(r.reward)) + frac_mul(cfg_discount, maxq));
      q = q_values[idx];
      nq = sat32(q + frac_mul(cfg_learn, tgt - q));
      q_values[idx] = nq[31:0];
      o.chosen_action = 3'(act);
      o.updated_value = nq[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] reg_image(reg_idx_t idx);
    case (idx)
      REG_LEARN_RATE:        return {16'd0, cfg_learn};
      REG_DISCOUNT:          return {16'd0, cfg_discount};
      REG_EXPLORE_THRESHOLD: return {16'd0, cfg_explore};
      REG_ACTIONS_IN_USE:    return {28'd0, cfg_actions};
      default:               return 32'd0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Present one request, hold it until the transfer, then idle between bursts
  task automatic send_req(input req_t r);
    rsp_t exp_rsp;
    int   gap;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    exp_rsp = step_q_engine(r);
    action_value_queue.push_back(exp_rsp);
    if (r.req_type == REQ_CHOOSE) n_choose++;
    else n_update++;
    if (exp_rsp.explored) n_explored++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // Drop start and wait until every awaited result has arrived
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (action_value_queue.size() != 0) @(posedge clk);
  endtask

  function automatic req_t choose_req(logic [7:0] st, logic [15:0] dice, logic [2:0] ra);
    req_t r;
    r = '0;
    r.req_type      = REQ_CHOOSE;
    r.state_index   = st;
    r.dice          = dice;
    r.random_action = ra;
    // fields an choose ignores get noise
    r.action_index  = 3'($urandom);
    r.reward        = $urandom;
    r.next_state    = 8'($urandom);
    return r;
  endfunction

  function automatic req_t update_req(logic [7:0] st, logic [2:0] act,
                                      logic signed [31:0] rw, logic [7:0] nx);
    req_t r;
    r = '0;
    r.req_type      = REQ_UPDATE;
    r.state_index   = st;
    r.action_index  = act;
    r.reward        = rw;
    r.next_state    = nx;
    r.dice          = 16'($urandom);
    r.random_action = 3'($urandom);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------

  task automatic read_reg(input reg_idx_t idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_image(idx)) begin
      $error("prdata[%s]: expected %0d, got %0d", idx.name(), reg_image(idx), prdata);
      fails++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register while idle, then read it back
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LEARN_RATE:        cfg_learn    = val;
      REG_DISCOUNT:          cfg_discount = val;
      REG_EXPLORE_THRESHOLD: cfg_explore  = val;
      REG_ACTIONS_IN_USE:    cfg_actions  = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_reg(idx);
  endtask

  task automatic write_all_regs(input logic [15:0] lr, input logic [15:0] disc,
                                input logic [15:0] thr, input logic [3:0] acts);
    write_reg(REG_LEARN_RATE, lr);
    write_reg(REG_DISCOUNT, disc);
    write_reg(REG_EXPLORE_THRESHOLD, thr);
    write_reg(REG_ACTIONS_IN_USE, {12'd0, acts});
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, zeroed table, explore boundary at the default threshold
  task automatic test_reset_defaults();
    read_reg(REG_LEARN_RATE);
    read_reg(REG_DISCOUNT);
    read_reg(REG_EXPLORE_THRESHOLD);
    read_reg(REG_ACTIONS_IN_USE);
    send_req(choose_req(8'd0, 16'hFFFF, 3'd3));
    send_req(choose_req(8'd0, 16'd0, 3'd7));
    send_req(choose_req(8'd255, 16'd6553, 3'd5));
    send_req(choose_req(8'd255, 16'd6554, 3'd5));
  endtask

  // Greedy pick: lowest action wins a tie, negative entries lose
  task automatic test_greedy_ties();
    write_reg(REG_EXPLORE_THRESHOLD, 16'd0);
    write_reg(REG_LEARN_RATE, 16'hFFFF);
    send_req(update_req(8'd5, 3'd2, 32'sh00010000, 8'd200));
    send_req(update_req(8'd5, 3'd5, 32'sh00010000, 8'd200));
    send_req(update_req(8'd5, 3'd6, -32'sh00010000, 8'd200));
    send_req(choose_req(8'd5, 16'hFFFF, 3'd6));
    send_req(update_req(8'd9, 3'd0, 32'sd0, 8'd5));
  endtask

  // Action count of zero, above the table width, and out-of-range actions
  task automatic test_action_count();
    write_reg(REG_ACTIONS_IN_USE, 16'd3);
    send_req(update_req(8'd20, 3'd7, 32'sh00020000, 8'd21));
    send_req(choose_req(8'd20, 16'd100, 3'd0));
    write_reg(REG_EXPLORE_THRESHOLD, 16'hFFFF);
    send_req(choose_req(8'd20, 16'd0, 3'd7));
    write_reg(REG_ACTIONS_IN_USE, 16'd0);
    send_req(choose_req(8'd20, 16'd0, 3'd5));
    send_req(update_req(8'd20, 3'd6, 32'sh00030000, 8'd20));
    write_reg(REG_ACTIONS_IN_USE, 16'd15);
    send_req(choose_req(8'd20, 16'hFFFE, 3'd7));
    write_reg(REG_EXPLORE_THRESHOLD, 16'd0);
    send_req(choose_req(8'd5, 16'd0, 3'd1));
  endtask

  // Drive the target into both saturation limits and the zero-rate corners
  task automatic test_saturation();
    write_reg(REG_DISCOUNT, 16'hFFFF);
    repeat (3) send_req(update_req(8'd255, 3'd7, 32'sh7FFFFFFF, 8'd255));
    send_req(choose_req(8'd255, 16'd0, 3'd0));
    repeat (3) send_req(update_req(8'd255, 3'd7, 32'sh80000000, 8'd255));
    write_reg(REG_LEARN_RATE, 16'd0);
    send_req(update_req(8'd255, 3'd7, 32'sh7FFFFFFF, 8'd255));
    write_reg(REG_LEARN_RATE, 16'hFFFF);
    write_reg(REG_DISCOUNT, 16'd0);
    send_req(update_req(8'd255, 3'd7, 32'sh7FFFFFFF, 8'd255));
  endtask

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t random_req();
    req_t        r;
    logic [19:0] small_rw;
    r.req_type      = 1'($urandom);
    r.state_index   = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.next_state    = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    r.action_index  = 3'($urandom);
    r.random_action = 3'($urandom);
    small_rw = 20'($urandom);
    case ($urandom_range(0, 9))
      0:       r.reward = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1, 2, 3: r.reward = $urandom;
      default: r.reward = {{12{small_rw[19]}}, small_rw};
    endcase
    // Land near the explore threshold now and then
    if ($urandom_range(0, 4) == 0) r.dice = 16'(cfg_explore + $urandom_range(0, 2) - 1);
    else r.dice = 16'($urandom);
    return r;
  endfunction

  // Random traffic over several register settings, defaults and extremes first
  task automatic test_random();
    logic [3:0] acts;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      acts = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      case (ph)
        0: write_all_regs(LEARN_RATE_RST, DISCOUNT_RST, EXPLORE_THRESHOLD_RST,
                          ACTIONS_IN_USE_RST);
        1: write_all_regs(16'hFFFF, 16'd0, 16'd0, 4'd8);
        2: write_all_regs(16'd0, 16'hFFFF, 16'hFFFF, 4'd1);
        default: write_all_regs(pick_frac(), pick_frac(), pick_frac(), acts);
      endcase
      repeat (RANDOM_ITEMS / RANDOM_PHASES) send_req(random_req());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && done) begin
      if (action_value_queue.size() == 0) begin
        $error("result with nothing awaited: action %0d value %0d",
               result.chosen_action, result.updated_value);
        fails++;
      end else begin
        want = action_value_queue.pop_front();
        if (result.chosen_action !== want.chosen_action) begin
          $error("chosen_action: expected %0d, got %0d", want.chosen_action,
                 result.chosen_action);
          fails++;
        end
        if (result.explored !== want.explored) begin
          $error("explored: expected %0d, got %0d", want.explored, result.explored);
          fails++;
        end
        if (result.updated_value !== want.updated_value) begin
          $error("updated_value: expected %0d, got %0d", want.updated_value,
                 result.updated_value);
          fails++;
        end
      end
    end
  end

  // Stop the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((start && !busy) || done || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    req         <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    fails        = 0;
    burst_left   = 0;
    n_choose     = 0;
    n_update     = 0;
    n_explored   = 0;
    n_settings   = 1;
    for (int i = 0; i < TABLE_DEPTH; i++) q_values[i] = '0;
    cfg_learn    = LEARN_RATE_RST;
    cfg_discount = DISCOUNT_RST;
    cfg_explore  = EXPLORE_THRESHOLD_RST;
    cfg_actions  = ACTIONS_IN_USE_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // hold off until the table clear finishes
    do @(posedge clk); while (busy);

    test_reset_defaults();
    test_greedy_ties();
    test_action_count();
    test_saturation();
    test_random();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (action_value_queue.size() != 0) begin
      $error("%0d results never arrived", action_value_queue.size());
      fails++;
    end

    $display("Ran %0d choose requests (%0d explored) and %0d table updates",
             n_choose, n_explored, n_update);
    $display("across %0d full register settings plus directed register changes",
             n_settings);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
